FILE: rtl/aig_pkg.sv
// Shared types, substitution tables and constants for the AES-256 IGE block cipher.
package aig_pkg;

  localparam int unsigned NumRounds = 14;
  localparam int unsigned NumRk     = NumRounds + 1;
  localparam int unsigned SchedWords = 4 * NumRk;

  typedef logic [3:0]   rnd_t;
  typedef logic [127:0] blk_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_OUT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    KE_LOAD,
    KE_RUN,
    KE_DONE
  } ke_state_e;

  typedef enum logic [2:0] {
    REG_KEY0 = 3'd0,
    REG_KEY1 = 3'd1,
    REG_KEY2 = 3'd2,
    REG_KEY3 = 3'd3,
    REG_DIR  = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic ready;
  } ke_status_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

FILE: rtl/aig_keyexp.sv
// AES-256 key schedule sequencer, one schedule word per cycle, with the round key store.
module aig_keyexp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [255:0]        key_i,
  input  aig_pkg::rnd_t       rk_idx_i,
  output aig_pkg::blk_t       rk_o,
  output aig_pkg::ke_status_t status_o
);

  aig_pkg::ke_state_e state_q, state_d;
  logic [5:0]   widx_q;
  logic [7:0]   rcon_q;
  logic [31:0]  win_q [8];
  aig_pkg::blk_t rk_q [aig_pkg::NumRk];
  logic [31:0]  t_rot, t_sub, t_sel, w_new;
  logic         last_word;

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {aig_pkg::SBOX[w[31:24]], aig_pkg::SBOX[w[23:16]],
            aig_pkg::SBOX[w[15:8]], aig_pkg::SBOX[w[7:0]]};
  endfunction

  assign t_rot = sub_word({win_q[7][23:0], win_q[7][31:24]}) ^ {rcon_q, 24'h0};
  assign t_sub = sub_word(win_q[7]);
  always_comb begin
    case (widx_q[2:0])
      3'd0:    t_sel = t_rot;
      3'd4:    t_sel = t_sub;
      default: t_sel = win_q[7];
    endcase
  end
  assign w_new     = win_q[0] ^ t_sel;
  assign last_word = (widx_q == 6'(aig_pkg::SchedWords - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      aig_pkg::KE_LOAD: state_d = aig_pkg::KE_RUN;
      aig_pkg::KE_RUN:  if (last_word) state_d = aig_pkg::KE_DONE;
      aig_pkg::KE_DONE: state_d = aig_pkg::KE_DONE;
      default:          state_d = aig_pkg::KE_LOAD;
    endcase
    if (start_i) state_d = aig_pkg::KE_LOAD;
  end

  always_comb begin
    status_o.ready = (state_q == aig_pkg::KE_DONE) && !start_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aig_pkg::KE_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == aig_pkg::KE_LOAD) begin
      for (int i = 0; i < 8; i++) begin
        win_q[i] <= key_i[255 - 32 * i -: 32];
      end
      rk_q[0] <= key_i[255:128];
      rk_q[1] <= key_i[127:0];
      widx_q  <= 6'd8;
      rcon_q  <= 8'h01;
    end else if (state_q == aig_pkg::KE_RUN) begin
      for (int i = 0; i < 7; i++) begin
        win_q[i] <= win_q[i + 1];
      end
      win_q[7] <= w_new;
      rk_q[widx_q[5:2]][(7'd96 - {widx_q[1:0], 5'd0}) +: 32] <= w_new;
      widx_q <= widx_q + 6'd1;
      if (widx_q[2:0] == 3'd0) begin
        rcon_q <= aig_pkg::xtime(rcon_q);
      end
    end
  end

  assign rk_o = rk_q[rk_idx_i];

endmodule

FILE: rtl/aig_round.sv
// One AES round, forward or inverse, applied to the state by the sequencer each cycle.
module aig_round (
  input  aig_pkg::blk_t state_i,
  input  aig_pkg::blk_t rk_i,
  input  logic          decrypt_i,
  input  logic          last_i,
  output aig_pkg::blk_t state_o
);

  logic [7:0] s  [16];
  logic [7:0] fw [16];
  logic [7:0] iv [16];
  logic [7:0] fm [16];
  logic [7:0] im [16];
  aig_pkg::blk_t fw_b, fm_b, iv_b, im_b;
  logic [7:0] a0, a1, a2, a3, x2, x4, x8;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = state_i[127 - 8 * i -: 8];
    end
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        fw[r + 4 * c] = aig_pkg::SBOX[s[r + 4 * ((c + r) % 4)]];
        iv[r + 4 * c] = aig_pkg::INV_SBOX[s[r + 4 * ((c + 4 - r) % 4)]]
                        ^ rk_i[127 - 8 * (r + 4 * c) -: 8];
      end
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        a0 = fw[4 * c + r];
        a1 = fw[4 * c + (r + 1) % 4];
        a2 = fw[4 * c + (r + 2) % 4];
        a3 = fw[4 * c + (r + 3) % 4];
        fm[4 * c + r] = aig_pkg::xtime(a0) ^ aig_pkg::xtime(a1) ^ a1 ^ a2 ^ a3;
        a0 = iv[4 * c + r];
        x2 = aig_pkg::xtime(a0);
        x4 = aig_pkg::xtime(x2);
        x8 = aig_pkg::xtime(x4);
        im[4 * c + r] = x8 ^ x4 ^ x2;
        a1 = iv[4 * c + (r + 1) % 4];
        x2 = aig_pkg::xtime(a1);
        x8 = aig_pkg::xtime(aig_pkg::xtime(x2));
        im[4 * c + r] = im[4 * c + r] ^ x8 ^ x2 ^ a1;
        a2 = iv[4 * c + (r + 2) % 4];
        x4 = aig_pkg::xtime(aig_pkg::xtime(a2));
        x8 = aig_pkg::xtime(x4);
        im[4 * c + r] = im[4 * c + r] ^ x8 ^ x4 ^ a2;
        a3 = iv[4 * c + (r + 3) % 4];
        x8 = aig_pkg::xtime(aig_pkg::xtime(aig_pkg::xtime(a3)));
        im[4 * c + r] = im[4 * c + r] ^ x8 ^ a3;
      end
    end
    for (int i = 0; i < 16; i++) begin
      fw_b[127 - 8 * i -: 8] = fw[i];
      fm_b[127 - 8 * i -: 8] = fm[i];
      iv_b[127 - 8 * i -: 8] = iv[i];
      im_b[127 - 8 * i -: 8] = im[i];
    end
    if (decrypt_i) begin
      state_o = last_i ? iv_b : im_b;
    end else begin
      state_o = (last_i ? fw_b : fm_b) ^ rk_i;
    end
  end

endmodule

FILE: rtl/aes256_ige_block_cipher.sv
// Top level of the AES-256 IGE block cipher: configuration, chaining and round sequencer.
//
//   channel  direction  handshake               payload
//   in       to block   in_valid_i/in_ready_o   start_message, iv_c_*, iv_p_*, data_in_*
//   out      from block out_valid_o/out_ready_i data_out_hi, data_out_lo
//   cfg      to block   cfg_we_i                cfg_index_i, cfg_data_i
//
// The accepting edge applies the first round key, and the remaining rounds then run in turn
// through the single shared round unit; the result is registered in out_q with the last round.
// After reset and after each key write the key schedule reloads the key and runs, one word a
// cycle, and no request is accepted until it finishes.
// The next request is accepted only after the result has been taken and the sequencer has
// returned to idle, so a new request is never taken while a block is in flight.
module aes256_ige_block_cipher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        start_message_i,
  input  logic [63:0] iv_c_hi_i,
  input  logic [63:0] iv_c_lo_i,
  input  logic [63:0] iv_p_hi_i,
  input  logic [63:0] iv_p_lo_i,
  input  logic [63:0] data_in_hi_i,
  input  logic [63:0] data_in_lo_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] data_out_hi_o,
  output logic [63:0] data_out_lo_o
);

  aig_pkg::ctrl_state_e state_q, state_d;
  aig_pkg::ke_status_t  ke_status;
  logic [255:0]  key_q;
  logic          dir_q;
  logic          kick_q;
  aig_pkg::blk_t prev_c_q, prev_p_q, din_q, blk_q, out_q;
  aig_pkg::blk_t pc, pp, din, rk, rnd_out, res;
  aig_pkg::rnd_t rnd_q, rk_idx;
  logic          in_acc, last_rnd;

  assign in_ready_o = (state_q == aig_pkg::ST_IDLE) && ke_status.ready;
  assign in_acc     = in_valid_i && in_ready_o;
  assign din = {data_in_hi_i, data_in_lo_i};
  assign pc  = start_message_i ? {iv_c_hi_i, iv_c_lo_i} : prev_c_q;
  assign pp  = start_message_i ? {iv_p_hi_i, iv_p_lo_i} : prev_p_q;

  assign last_rnd = dir_q ? (rnd_q == 4'd0) : (rnd_q == 4'(aig_pkg::NumRounds));
  assign rk_idx = (state_q == aig_pkg::ST_IDLE)
                ? (dir_q ? 4'(aig_pkg::NumRounds) : 4'd0) : rnd_q;
  assign res = rnd_out ^ (dir_q ? prev_c_q : prev_p_q);

  aig_keyexp u_keyexp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (kick_q),
    .key_i    (key_q),
    .rk_idx_i (rk_idx),
    .rk_o     (rk),
    .status_o (ke_status)
  );

  aig_round u_round (
    .state_i   (blk_q),
    .rk_i      (rk),
    .decrypt_i (dir_q),
    .last_i    (last_rnd),
    .state_o   (rnd_out)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      aig_pkg::ST_IDLE: if (in_acc) state_d = aig_pkg::ST_RUN;
      aig_pkg::ST_RUN:  if (last_rnd) state_d = aig_pkg::ST_OUT;
      aig_pkg::ST_OUT:  if (out_ready_i) state_d = aig_pkg::ST_IDLE;
      default:          state_d = aig_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_o   = (state_q == aig_pkg::ST_OUT);
    data_out_hi_o = out_q[127:64];
    data_out_lo_o = out_q[63:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= aig_pkg::ST_IDLE;
      key_q    <= '0;
      dir_q    <= 1'b0;
      kick_q   <= 1'b1;
      prev_c_q <= '0;
      prev_p_q <= '0;
    end else begin
      state_q <= state_d;
      kick_q  <= cfg_we_i && (cfg_index_i inside {aig_pkg::REG_KEY0, aig_pkg::REG_KEY1,
                                                   aig_pkg::REG_KEY2, aig_pkg::REG_KEY3});
      if (cfg_we_i) begin
        case (cfg_index_i)
          aig_pkg::REG_KEY0: key_q[255:192] <= cfg_data_i;
          aig_pkg::REG_KEY1: key_q[191:128] <= cfg_data_i;
          aig_pkg::REG_KEY2: key_q[127:64]  <= cfg_data_i;
          aig_pkg::REG_KEY3: key_q[63:0]    <= cfg_data_i;
          aig_pkg::REG_DIR:  dir_q          <= cfg_data_i[0];
          default:           ;
        endcase
      end
      if (in_acc) begin
        prev_c_q <= pc;
        prev_p_q <= pp;
      end else if ((state_q == aig_pkg::ST_RUN) && last_rnd) begin
        if (dir_q) begin
          prev_p_q <= res;
          prev_c_q <= din_q;
        end else begin
          prev_c_q <= res;
          prev_p_q <= din_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      din_q <= din;
      blk_q <= din ^ (dir_q ? pp : pc) ^ rk;
      rnd_q <= dir_q ? 4'(aig_pkg::NumRounds - 1) : 4'd1;
    end else if (state_q == aig_pkg::ST_RUN) begin
      blk_q <= rnd_out;
      rnd_q <= dir_q ? rnd_q - 4'd1 : rnd_q + 4'd1;
      if (last_rnd) begin
        out_q <= res;
      end
    end
  end

  a_no_accept_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("request accepted while a result waits");

  a_accept_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == aig_pkg::ST_RUN))
    else $error("accepted request did not start rounds");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(data_out_hi_o)))
    else $error("result dropped before it was taken");

endmodule

FILE: sim/tb_aes256_ige_block_cipher.sv
// Self-checking testbench for the AES-256 IGE block cipher with a chained-block predictor.
module tb_aes256_ige_block_cipher;

  localparam logic [2:0] IdxSpareLo = 3'd5;
  localparam logic [2:0] IdxSpareHi = 3'd7;
  localparam int unsigned CycleLimit = 2000000;

  typedef logic [7:0] aes_state_t [16];

  class IgeScoreboard;
    logic [63:0]  key_w [4];
    logic         decrypt;
    logic [127:0] last_cipher;
    logic [127:0] last_plain;
    logic [31:0]  sched [60];
    logic [127:0] pending_out [$];
    logic [7:0]   inv_tab [256];

    function new();
      for (int i = 0; i < 256; i++) inv_tab[aig_pkg::SBOX[i]] = i[7:0];
      foreach (key_w[i]) key_w[i] = '0;
      decrypt = 1'b0;
      last_cipher = '0;
      last_plain = '0;
      expand();
    endfunction

    function logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
      logic [7:0] r;
      r = '0;
      for (int i = 0; i < 8; i++) begin
        if (b[i]) r ^= a;
        a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      end
      return r;
    endfunction

    function logic [31:0] sub_w(logic [31:0] w);
      return {aig_pkg::SBOX[w[31:24]], aig_pkg::SBOX[w[23:16]],
              aig_pkg::SBOX[w[15:8]], aig_pkg::SBOX[w[7:0]]};
    endfunction

    function void expand();
      logic [31:0] t;
      logic [7:0] rc;
      rc = 8'h01;
      for (int i = 0; i < 8; i++) sched[i] = i[0] ? key_w[i/2][31:0] : key_w[i/2][63:32];
      for (int i = 8; i < 60; i++) begin
        t = sched[i-1];
        if (i % 8 == 0) begin
          t = sub_w({t[23:0], t[31:24]}) ^ {rc, 24'h0};
          rc = gf_mul(rc, 8'h02);
        end else if (i % 8 == 4) begin
          t = sub_w(t);
        end
        sched[i] = sched[i-8] ^ t;
      end
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] val);
      if (idx < 3'd4) begin
        key_w[idx[1:0]] = val;
        expand();
      end else if (idx == aig_pkg::REG_DIR) begin
        decrypt = val[0];
      end
    endfunction

    function aes_state_t add_key(aes_state_t s, int r);
      logic [127:0] k;
      k = {sched[4*r], sched[4*r+1], sched[4*r+2], sched[4*r+3]};
      for (int i = 0; i < 16; i++) s[i] ^= k[127-8*i -: 8];
      return s;
    endfunction

    function aes_state_t shift(aes_state_t s, bit inv);
      aes_state_t t;
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++) begin
          if (inv) t[r + 4*((c+r) & 3)] = s[r + 4*c];
          else t[r + 4*c] = s[r + 4*((c+r) & 3)];
        end
      return t;
    endfunction

    function aes_state_t mix(aes_state_t s, bit inv);
      logic [7:0] a [4];
      logic [7:0] m0, m1, m2, m3;
      m0 = inv ? 8'h0e : 8'h02;
      m1 = inv ? 8'h0b : 8'h03;
      m2 = inv ? 8'h0d : 8'h01;
      m3 = inv ? 8'h09 : 8'h01;
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) a[r] = s[4*c+r];
        for (int r = 0; r < 4; r++)
          s[4*c+r] = gf_mul(a[r], m0) ^ gf_mul(a[(r+1)&3], m1) ^
                     gf_mul(a[(r+2)&3], m2) ^ gf_mul(a[(r+3)&3], m3);
      end
      return s;
    endfunction

    function logic [127:0] cipher(logic [127:0] v, bit inv);
      aes_state_t s;
      logic [127:0] o;
      for (int i = 0; i < 16; i++) s[i] = v[127-8*i -: 8];
      if (!inv) begin
        s = add_key(s, 0);
        for (int r = 1; r <= 14; r++) begin
          for (int i = 0; i < 16; i++) s[i] = aig_pkg::SBOX[s[i]];
          s = shift(s, 1'b0);
          if (r != 14) s = mix(s, 1'b0);
          s = add_key(s, r);
        end
      end else begin
        s = add_key(s, 14);
        for (int r = 13; r >= 0; r--) begin
          s = shift(s, 1'b1);
          for (int i = 0; i < 16; i++) s[i] = inv_tab[s[i]];
          s = add_key(s, r);
          if (r != 0) s = mix(s, 1'b1);
        end
      end
      for (int i = 0; i < 16; i++) o[127-8*i -: 8] = s[i];
      return o;
    endfunction

    function void note_block(logic start, logic [127:0] ivc, logic [127:0] ivp,
                             logic [127:0] din);
      logic [127:0] o;
      if (start) begin
        last_cipher = ivc;
        last_plain = ivp;
      end
      if (!decrypt) begin
        o = cipher(din ^ last_cipher, 1'b0) ^ last_plain;
        last_cipher = o;
        last_plain = din;
      end else begin
        o = cipher(din ^ last_plain, 1'b1) ^ last_cipher;
        last_plain = o;
        last_cipher = din;
      end
      pending_out.push_back(o);
    endfunction

    function bit check_block(logic [127:0] got, output string why);
      logic [127:0] want;
      why = "";
      if (pending_out.size() == 0) begin
        why = $sformatf("unexpected result %h", got);
        return 1'b0;
      end
      want = pending_out.pop_front();
      if (got[127:64] !== want[127:64])
        why = $sformatf("data_out_hi %h, expected %h", got[127:64], want[127:64]);
      else if (got[63:0] !== want[63:0])
        why = $sformatf("data_out_lo %h, expected %h", got[63:0], want[63:0]);
      return why == "";
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        start_message_i = 1'b0;
  logic [63:0] iv_c_hi_i = '0;
  logic [63:0] iv_c_lo_i = '0;
  logic [63:0] iv_p_hi_i = '0;
  logic [63:0] iv_p_lo_i = '0;
  logic [63:0] data_in_hi_i = '0;
  logic [63:0] data_in_lo_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] data_out_hi_o;
  logic [63:0] data_out_lo_o;

  IgeScoreboard chain_sb = new();
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit          calm = 1'b0;

  aes256_ige_block_cipher u_top (.*);

  always #1 clk_i = ~clk_i;

  task automatic report(string why);
    errors++;
    $display("ERROR at cycle %0d: %s", cycles, why);
  endtask

  always @(posedge clk_i) begin
    string why;
    cycles++;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        chain_sb.note_block(start_message_i, {iv_c_hi_i, iv_c_lo_i},
                            {iv_p_hi_i, iv_p_lo_i}, {data_in_hi_i, data_in_lo_i});
      if (out_valid_o && out_ready_i)
        if (!chain_sb.check_block({data_out_hi_o, data_out_lo_o}, why)) report(why);
    end
    if (cycles > CycleLimit) begin
      $display("aes256_ige_block_cipher: mismatch");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    int unsigned stall;
    if (!calm && $urandom_range(0, 9) == 0) begin
      stall = $urandom_range(1, 12);
      out_ready_i = 1'b0;
      repeat (stall) @(negedge clk_i);
    end
    out_ready_i = 1'b1;
  end

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send_block(logic start, logic [63:0] ch, logic [63:0] cl,
                            logic [63:0] ph, logic [63:0] pl,
                            logic [63:0] dh, logic [63:0] dl);
    int unsigned gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      repeat (gap) @(negedge clk_i);
    end
    start_message_i = start;
    iv_c_hi_i = ch;
    iv_c_lo_i = cl;
    iv_p_hi_i = ph;
    iv_p_lo_i = pl;
    data_in_hi_i = dh;
    data_in_lo_i = dl;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic drain();
    @(posedge clk_i);
    while (chain_sb.pending_out.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    @(posedge clk_i);
    chain_sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic send_rand(logic start);
    send_block(start, rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), rnd64());
  endtask

  initial begin
    int unsigned sent;
    int unsigned len;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed blocks: zero chaining after reset, field extremes, ignored IVs.
    send_block(1'b0, '0, '0, '0, '0, '0, '0);
    send_block(1'b0, '1, '1, '1, '1, '1, '1);
    send_block(1'b1, '1, '1, '1, '1, '0, '0);
    send_block(1'b1, '0, '0, '0, '0, '1, '1);
    send_rand(1'b0);
    drain();
    write_reg(aig_pkg::REG_KEY0, '1);
    write_reg(aig_pkg::REG_KEY1, '1);
    write_reg(aig_pkg::REG_KEY2, '1);
    write_reg(aig_pkg::REG_KEY3, '1);
    write_reg(aig_pkg::REG_DIR, 64'd1);
    write_reg(IdxSpareLo, '0);
    write_reg(IdxSpareHi, '0);
    send_block(1'b1, '0, '0, '0, '0, '0, '0);
    send_block(1'b0, '1, '1, '1, '1, '1, '1);
    send_rand(1'b1);
    drain();
    // The direction flips in the middle of a message.
    write_reg(aig_pkg::REG_DIR, 64'd0);
    send_rand(1'b0);
    send_rand(1'b0);
    drain();
    // The key changes in the middle of a message.
    write_reg(aig_pkg::REG_KEY2, rnd64());
    send_rand(1'b0);
    send_rand(1'b0);
    drain();
    write_reg(aig_pkg::REG_DIR, '1);
    send_rand(1'b0);
    send_rand(1'b1);
    drain();

    sent = 0;
    while (sent < 1500) begin
      if ($urandom_range(0, 3) == 0) begin
        drain();
        for (int i = 0; i < 4; i++)
          if ($urandom_range(0, 1)) write_reg(3'(aig_pkg::REG_KEY0 + i), rnd64());
        if ($urandom_range(0, 1))
          write_reg(aig_pkg::REG_DIR, {63'h0, 1'($urandom_range(0, 1))});
        if ($urandom_range(0, 7) == 0) write_reg(3'($urandom_range(5, 7)), rnd64());
      end
      calm = sent > 1300;
      len = $urandom_range(1, 10);
      for (int i = 0; i < len; i++) begin
        send_rand(i == 0 ? $urandom_range(0, 7) != 0 : $urandom_range(0, 15) == 0);
        sent++;
      end
    end

    calm = 1'b1;
    drain();
    repeat (40) @(posedge clk_i);
    if (errors == 0 && chain_sb.pending_out.size() == 0) begin
      $display("aes256_ige_block_cipher: match");
    end else begin
      $display("aes256_ige_block_cipher: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/aig_pkg.sv
rtl/aig_keyexp.sv
rtl/aig_round.sv
rtl/aes256_ige_block_cipher.sv
sim/tb_aes256_ige_block_cipher.sv
